FILE: design/hdbp_pkg.sv
package hdbp_pkg;

   localparam int MaxKeywordChars = 9;
   localparam int KwBytes         = 9;
   localparam int KwLenW          = 4;
   localparam int CandW           = 23;
   localparam int WdayCount       = 14;
   localparam int MonCount        = 23;
   localparam int ZoneCount       = 18;
   localparam int NumMax          = 65535;
   localparam int YearBias        = 1900;

   localparam logic [CandW-1:0] ALL_LIVE = {CandW{1'b1}};

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   typedef enum logic [1:0] {
      CMD_BYTE    = 2'd0,
      CMD_END     = 2'd1,
      CMD_RESTART = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_CONTINUE = 2'd0,
      ST_COMPLETE = 2'd1,
      ST_ERROR    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      KW_WDAY = 2'd0,
      KW_MON  = 2'd1,
      KW_ZONE = 2'd2
   } kw_table_type;

   typedef enum logic [15:0] {
      PH_START     = 16'h0001,
      PH_WEEKDAY   = 16'h0002,
      PH_PRE_DAY   = 16'h0004,
      PH_DAY       = 16'h0008,
      PH_PRE_MONTH = 16'h0010,
      PH_MONTH     = 16'h0020,
      PH_PRE_YEAR  = 16'h0040,
      PH_YEAR      = 16'h0080,
      PH_PRE_HOUR  = 16'h0100,
      PH_HOUR      = 16'h0200,
      PH_MINUTE    = 16'h0400,
      PH_SECOND    = 16'h0800,
      PH_PRE_ZONE  = 16'h1000,
      PH_ZONE      = 16'h2000,
      PH_DONE      = 16'h4000,
      PH_ERR       = 16'h8000
   } phase_type;

   // Keyword text is held right-justified: the last character sits in the low byte.
   typedef struct packed {
      logic                 vld;
      logic [KwBytes*8-1:0] txt;
      logic [KwLenW-1:0]    len;
      logic [3:0]           val;
   } kw_entry_type;

   localparam kw_entry_type WDAY_TAB [WdayCount] = '{
      '{1'b1, "Fri", 4'd3, 4'd0}, '{1'b1, "Friday", 4'd6, 4'd0},
      '{1'b1, "Mon", 4'd3, 4'd0}, '{1'b1, "Monday", 4'd6, 4'd0},
      '{1'b1, "Sat", 4'd3, 4'd0}, '{1'b1, "Saturday", 4'd8, 4'd0},
      '{1'b1, "Sun", 4'd3, 4'd0}, '{1'b1, "Sunday", 4'd6, 4'd0},
      '{1'b1, "Thu", 4'd3, 4'd0}, '{1'b1, "Thursday", 4'd8, 4'd0},
      '{1'b1, "Tue", 4'd3, 4'd0}, '{1'b1, "Tuesday", 4'd7, 4'd0},
      '{1'b1, "Wed", 4'd3, 4'd0}, '{1'b1, "Wednesday", 4'd9, 4'd0}
   };

   localparam kw_entry_type MON_TAB [MonCount] = '{
      '{1'b1, "Apr", 4'd3, 4'd4},  '{1'b1, "April", 4'd5, 4'd4},
      '{1'b1, "Aug", 4'd3, 4'd8},  '{1'b1, "August", 4'd6, 4'd8},
      '{1'b1, "Dec", 4'd3, 4'd12}, '{1'b1, "December", 4'd8, 4'd12},
      '{1'b1, "Feb", 4'd3, 4'd2},  '{1'b1, "February", 4'd8, 4'd2},
      '{1'b1, "Jan", 4'd3, 4'd1},  '{1'b1, "January", 4'd7, 4'd1},
      '{1'b1, "Jul", 4'd3, 4'd7},  '{1'b1, "July", 4'd4, 4'd7},
      '{1'b1, "Jun", 4'd3, 4'd6},  '{1'b1, "June", 4'd4, 4'd6},
      '{1'b1, "Mar", 4'd3, 4'd3},  '{1'b1, "March", 4'd5, 4'd3},
      '{1'b1, "May", 4'd3, 4'd5},
      '{1'b1, "Nov", 4'd3, 4'd11}, '{1'b1, "November", 4'd8, 4'd11},
      '{1'b1, "Oct", 4'd3, 4'd10}, '{1'b1, "October", 4'd7, 4'd10},
      '{1'b1, "Sep", 4'd3, 4'd9},  '{1'b1, "September", 4'd9, 4'd9}
   };

   localparam kw_entry_type ZONE_TAB [ZoneCount] = '{
      '{1'b1, "ADT", 4'd3, 4'd0}, '{1'b1, "AST", 4'd3, 4'd0},
      '{1'b1, "BDT", 4'd3, 4'd0}, '{1'b1, "BST", 4'd3, 4'd0},
      '{1'b1, "CDT", 4'd3, 4'd0}, '{1'b1, "CST", 4'd3, 4'd0},
      '{1'b1, "EDT", 4'd3, 4'd0}, '{1'b1, "EST", 4'd3, 4'd0},
      '{1'b1, "GMT", 4'd3, 4'd0}, '{1'b1, "HDT", 4'd3, 4'd0},
      '{1'b1, "HST", 4'd3, 4'd0}, '{1'b1, "MDT", 4'd3, 4'd0},
      '{1'b1, "MST", 4'd3, 4'd0}, '{1'b1, "NST", 4'd3, 4'd0},
      '{1'b1, "PDT", 4'd3, 4'd0}, '{1'b1, "PST", 4'd3, 4'd0},
      '{1'b1, "YDT", 4'd3, 4'd0}, '{1'b1, "YST", 4'd3, 4'd0}
   };

   function automatic kw_entry_type kw_entry_at(kw_table_type tab, logic [4:0] idx);
      kw_entry_type ent;
      ent = '0;
      case (tab)
         KW_WDAY: begin
            if (idx < 5'(WdayCount)) ent = WDAY_TAB[idx[3:0]];
         end
         KW_MON: begin
            if (idx < 5'(MonCount)) ent = MON_TAB[idx];
         end
         KW_ZONE: begin
            if (idx < 5'(ZoneCount)) ent = ZONE_TAB[idx];
         end
         default: begin
            ent = '0;
         end
      endcase
      return ent;
   endfunction

   function automatic logic [7:0] kw_char(kw_entry_type ent, logic [KwLenW-1:0] pos);
      logic [KwLenW-1:0]    sh;
      logic [KwBytes*8-1:0] sft;
      sh  = ent.len - pos - 4'd1;
      sft = ent.txt >> {sh, 3'b000};
      return sft[7:0];
   endfunction

   function automatic logic is_dig(logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alp(logic [7:0] c);
      return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
   endfunction

   // Multiply by ten as two shifts and an add, then saturate.
   function automatic logic [15:0] acc_digit(logic [15:0] acc, logic [7:0] c);
      logic [19:0] v;
      v = 20'({acc, 3'b000}) + 20'({acc, 1'b0}) + 20'(c[3:0]);
      return (v > 20'(NumMax)) ? 16'(NumMax) : v[15:0];
   endfunction

endpackage

FILE: design/http_date_byte_parser_core.sv
// Each item is transferred into the input register and its result is then offered
// from the result register; throughput is one item per cycle while results are taken.
// The keyword match against all table entries and the multiply-by-ten of the
// number fields complete in the single stage between the two registers.
// Synchronous active-high reset returns the parser to the start phase with
// all date fields cleared and both stages empty.
module http_date_byte_parser_core #(
   parameter int MAX_KEYWORD_CHARS = hdbp_pkg::MaxKeywordChars
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_cmd,
   input  logic [7:0]         req_ch,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [15:0]        rsp_day,
   output logic [3:0]         rsp_month,
   output logic signed [16:0] rsp_year_since_1900,
   output logic [15:0]        rsp_hour,
   output logic [15:0]        rsp_minute,
   output logic [15:0]        rsp_second
);

   localparam int LenW = $clog2(MAX_KEYWORD_CHARS + 1);

   logic                        s1_valid_ff, s1_valid_in;
   logic [1:0]                  s1_cmd_ff;
   logic [7:0]                  s1_ch_ff;
   logic                        s1_adv;
   logic                        rsp_valid_ff, rsp_valid_in;
   hdbp_pkg::status_type        status_ff, status_in;

   hdbp_pkg::phase_type         phase_ff, phase_in;
   logic [hdbp_pkg::CandW-1:0]  cand_ff, cand_in;
   logic [LenW-1:0]             kl_ff, kl_in;
   logic [15:0]                 day_ff, day_in;
   logic [3:0]                  month_ff, month_in;
   logic signed [16:0]          year_ff, year_in;
   logic [15:0]                 hour_ff, hour_in;
   logic [15:0]                 minute_ff, minute_in;
   logic [15:0]                 second_ff, second_in;

   hdbp_pkg::kw_table_type      kw_tab;
   logic                        kw_fresh;
   logic                        kw_delim;
   logic [hdbp_pkg::CandW-1:0]  kw_next;
   logic                        kw_end_ok;
   logic [3:0]                  kw_val;
   logic                        kw_step_ok;
   logic [LenW-1:0]             kw_len_next;

   assign s1_adv      = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !s1_valid_ff || s1_adv;
   assign s1_valid_in = (req_valid && req_ready) || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_ready);

   // Select the keyword table and the name delimiters for the current phase.
   always_comb begin
      kw_fresh = 1'b0;
      case (phase_ff)
         hdbp_pkg::PH_START, hdbp_pkg::PH_WEEKDAY: begin
            kw_tab   = hdbp_pkg::KW_WDAY;
            kw_fresh = (phase_ff == hdbp_pkg::PH_START);
            kw_delim = (s1_ch_ff == hdbp_pkg::CH_SPACE) || (s1_ch_ff == hdbp_pkg::CH_COMMA);
         end
         hdbp_pkg::PH_PRE_MONTH, hdbp_pkg::PH_MONTH: begin
            kw_tab   = hdbp_pkg::KW_MON;
            kw_fresh = (phase_ff == hdbp_pkg::PH_PRE_MONTH);
            kw_delim = (s1_ch_ff == hdbp_pkg::CH_SPACE) || (s1_ch_ff == hdbp_pkg::CH_DASH);
         end
         default: begin
            kw_tab   = hdbp_pkg::KW_ZONE;
            kw_fresh = (phase_ff == hdbp_pkg::PH_PRE_ZONE);
            kw_delim = (s1_cmd_ff == hdbp_pkg::CMD_END) ||
                       (s1_ch_ff == hdbp_pkg::CH_SPACE) || (s1_ch_ff == hdbp_pkg::CH_CR) ||
                       (s1_ch_ff == hdbp_pkg::CH_LF);
         end
      endcase
   end

   // All table entries are compared against the incoming character at once.
   always_comb begin : kw_match
      hdbp_pkg::kw_entry_type      ent;
      logic [hdbp_pkg::CandW-1:0]  cand_eff;
      logic [hdbp_pkg::KwLenW-1:0] kl_eff;
      cand_eff  = kw_fresh ? hdbp_pkg::ALL_LIVE : cand_ff;
      kl_eff    = kw_fresh ? '0 : hdbp_pkg::KwLenW'(kl_ff);
      kw_next   = '0;
      kw_end_ok = 1'b0;
      kw_val    = '0;
      for (int i = 0; i < hdbp_pkg::CandW; i++) begin
         ent = hdbp_pkg::kw_entry_at(kw_tab, 5'(i));
         if (ent.vld && cand_eff[i]) begin
            if (ent.len == kl_eff) begin
               kw_end_ok = 1'b1;
               kw_val    = kw_val | ent.val;
            end
            if ((kl_eff < ent.len) && (hdbp_pkg::kw_char(ent, kl_eff) == s1_ch_ff)) begin
               kw_next[i] = 1'b1;
            end
         end
      end
      kw_step_ok  = (kl_eff < hdbp_pkg::KwLenW'(MAX_KEYWORD_CHARS)) && (|kw_next);
      kw_len_next = LenW'(kl_eff + 4'd1);
   end

   always_comb begin
      phase_in  = phase_ff;
      cand_in   = cand_ff;
      kl_in     = kl_ff;
      day_in    = day_ff;
      month_in  = month_ff;
      year_in   = year_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      status_in = hdbp_pkg::ST_CONTINUE;
      case (s1_cmd_ff)
         hdbp_pkg::CMD_BYTE: begin
            case (phase_ff)
               hdbp_pkg::PH_START, hdbp_pkg::PH_WEEKDAY: begin
                  if ((phase_ff == hdbp_pkg::PH_START) && hdbp_pkg::is_dig(s1_ch_ff)) begin
                     day_in   = 16'(s1_ch_ff[3:0]);
                     phase_in = hdbp_pkg::PH_DAY;
                  end else if (kw_delim) begin
                     if (kw_end_ok && (s1_ch_ff == hdbp_pkg::CH_COMMA)) begin
                        phase_in = hdbp_pkg::PH_PRE_DAY;
                     end else begin
                        status_in = hdbp_pkg::ST_ERROR;
                     end
                  end else if (kw_step_ok) begin
                     cand_in  = kw_next;
                     kl_in    = kw_len_next;
                     phase_in = hdbp_pkg::PH_WEEKDAY;
                  end else begin
                     status_in = hdbp_pkg::ST_ERROR;
                  end
               end
               hdbp_pkg::PH_PRE_DAY: begin
                  if (hdbp_pkg::is_dig(s1_ch_ff)) begin
                     day_in   = 16'(s1_ch_ff[3:0]);
                     phase_in = hdbp_pkg::PH_DAY;
                  end else if (s1_ch_ff != hdbp_pkg::CH_SPACE) begin
                     status_in = hdbp_pkg::ST_ERROR;
                  end
               end
               hdbp_pkg::PH_DAY: begin
                  if (hdbp_pkg::is_dig(s1_ch_ff)) begin
                     day_in = hdbp_pkg::acc_digit(day_ff, s1_ch_ff);
                  end else if ((s1_ch_ff == hdbp_pkg::CH_SPACE) ||
                               (s1_ch_ff == hdbp_pkg::CH_DASH)) begin
                     phase_in = hdbp_pkg::PH_PRE_MONTH;
                  end else begin
                     status_in = hdbp_pkg::ST_ERROR;
                  end
               end
               hdbp_pkg::PH_PRE_MONTH, hdbp_pkg::PH_MONTH: begin
                  if ((phase_ff == hdbp_pkg::PH_PRE_MONTH) && (s1_ch_ff == hdbp_pkg::CH_SPACE)) begin
                     phase_in = phase_ff;
                  end else if ((phase_ff == hdbp_pkg::PH_PRE_MONTH) &&
                               !hdbp_pkg::is_alp(s1_ch_ff)) begin
                     status_in = hdbp_pkg::ST_ERROR;
                  end else if (kw_delim) begin
                     if (kw_end_ok) begin
                        month_in = kw_val;
                        phase_in = hdbp_pkg::PH_PRE_YEAR;
                     end else begin
                        status_in = hdbp_pkg::ST_ERROR;
                     end
                  end else if (kw_step_ok) begin
                     cand_in  = kw_next;
                     kl_in    = kw_len_next;
                     phase_in = hdbp_pkg::PH_MONTH;
                  end else begin
                     status_in = hdbp_pkg::ST_ERROR;
                  end
               end
               hdbp_pkg::PH_PRE_YEAR: begin
                  if (hdbp_pkg::is_dig(s1_ch_ff)) begin
                     year_in  = 17'(s1_ch_ff[3:0]);
                     phase_in = hdbp_pkg::PH_YEAR;
                  end else if (s1_ch_ff != hdbp_pkg::CH_SPACE) begin
                     status_in = hdbp_pkg::ST_ERROR;
                  end
               end
               hdbp_pkg::PH_YEAR: begin
                  if (hdbp_pkg::is_dig(s1_ch_ff)) begin
                     year_in = {1'b0, hdbp_pkg::acc_digit(year_ff[15:0], s1_ch_ff)};
                  end else if (s1_ch_ff == hdbp_pkg::CH_SPACE) begin
                     year_in  = year_ff - 17'(hdbp_pkg::YearBias);
                     phase_in = hdbp_pkg::PH_PRE_HOUR;
                  end else begin
                     status_in = hdbp_pkg::ST_ERROR;
                  end
               end
               hdbp_pkg::PH_PRE_HOUR: begin
                  if (hdbp_pkg::is_dig(s1_ch_ff)) begin
                     hour_in  = 16'(s1_ch_ff[3:0]);
                     phase_in = hdbp_pkg::PH_HOUR;
                  end else if (s1_ch_ff != hdbp_pkg::CH_SPACE) begin
                     status_in = hdbp_pkg::ST_ERROR;
                  end
               end
               hdbp_pkg::PH_HOUR: begin
                  if (hdbp_pkg::is_dig(s1_ch_ff)) begin
                     hour_in = hdbp_pkg::acc_digit(hour_ff, s1_ch_ff);
                  end else if (s1_ch_ff == hdbp_pkg::CH_COLON) begin
                     minute_in = '0;
                     phase_in  = hdbp_pkg::PH_MINUTE;
                  end else begin
                     status_in = hdbp_pkg::ST_ERROR;
                  end
               end
               hdbp_pkg::PH_MINUTE: begin
                  if (hdbp_pkg::is_dig(s1_ch_ff)) begin
                     minute_in = hdbp_pkg::acc_digit(minute_ff, s1_ch_ff);
                  end else if (s1_ch_ff == hdbp_pkg::CH_COLON) begin
                     second_in = '0;
                     phase_in  = hdbp_pkg::PH_SECOND;
                  end else begin
                     status_in = hdbp_pkg::ST_ERROR;
                  end
               end
               hdbp_pkg::PH_SECOND: begin
                  if (hdbp_pkg::is_dig(s1_ch_ff)) begin
                     second_in = hdbp_pkg::acc_digit(second_ff, s1_ch_ff);
                  end else if (s1_ch_ff == hdbp_pkg::CH_SPACE) begin
                     phase_in = hdbp_pkg::PH_PRE_ZONE;
                  end else begin
                     status_in = hdbp_pkg::ST_ERROR;
                  end
               end
               hdbp_pkg::PH_PRE_ZONE, hdbp_pkg::PH_ZONE: begin
                  if ((phase_ff == hdbp_pkg::PH_PRE_ZONE) && (s1_ch_ff == hdbp_pkg::CH_SPACE)) begin
                     phase_in = phase_ff;
                  end else if ((phase_ff == hdbp_pkg::PH_PRE_ZONE) &&
                               !hdbp_pkg::is_alp(s1_ch_ff)) begin
                     status_in = hdbp_pkg::ST_ERROR;
                  end else if (kw_delim) begin
                     if (kw_end_ok) begin
                        status_in = hdbp_pkg::ST_COMPLETE;
                        phase_in  = hdbp_pkg::PH_DONE;
                     end else begin
                        status_in = hdbp_pkg::ST_ERROR;
                     end
                  end else if (kw_step_ok) begin
                     cand_in  = kw_next;
                     kl_in    = kw_len_next;
                     phase_in = hdbp_pkg::PH_ZONE;
                  end else begin
                     status_in = hdbp_pkg::ST_ERROR;
                  end
               end
               default: begin
                  status_in = hdbp_pkg::ST_ERROR;
               end
            endcase
         end
         hdbp_pkg::CMD_END: begin
            if ((phase_ff == hdbp_pkg::PH_ZONE) && kw_end_ok) begin
               status_in = hdbp_pkg::ST_COMPLETE;
               phase_in  = hdbp_pkg::PH_DONE;
            end else begin
               status_in = hdbp_pkg::ST_ERROR;
            end
         end
         hdbp_pkg::CMD_RESTART: begin
            phase_in  = hdbp_pkg::PH_START;
            cand_in   = hdbp_pkg::ALL_LIVE;
            kl_in     = '0;
            day_in    = '0;
            month_in  = '0;
            year_in   = '0;
            hour_in   = '0;
            minute_in = '0;
            second_in = '0;
         end
         default: begin
            status_in = hdbp_pkg::ST_CONTINUE;
         end
      endcase
      // An error is sticky; a completed date stays complete until restart.
      if ((status_in == hdbp_pkg::ST_ERROR) && (phase_ff != hdbp_pkg::PH_DONE)) begin
         phase_in = hdbp_pkg::PH_ERR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         status_ff    <= hdbp_pkg::ST_CONTINUE;
         phase_ff     <= hdbp_pkg::PH_START;
         cand_ff      <= hdbp_pkg::ALL_LIVE;
         kl_ff        <= '0;
         day_ff       <= '0;
         month_ff     <= '0;
         year_ff      <= '0;
         hour_ff      <= '0;
         minute_ff    <= '0;
         second_ff    <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_adv) begin
            status_ff <= status_in;
            phase_ff  <= phase_in;
            cand_ff   <= cand_in;
            kl_ff     <= kl_in;
            day_ff    <= day_in;
            month_ff  <= month_in;
            year_ff   <= year_in;
            hour_ff   <= hour_in;
            minute_ff <= minute_in;
            second_ff <= second_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_cmd_ff <= req_cmd;
         s1_ch_ff  <= req_ch;
      end
   end

   // The date registers only change when a result is loaded, so they double
   // as the result payload.
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_day             = day_ff;
   assign rsp_month           = month_ff;
   assign rsp_year_since_1900 = year_ff;
   assign rsp_hour            = hour_ff;
   assign rsp_minute          = minute_ff;
   assign rsp_second          = second_ff;

endmodule

FILE: bench/http_date_checker.sv
`timescale 1ns / 1ps
module http_date_checker #(
   parameter int NAME_LIMIT = hdbp_pkg::MaxKeywordChars
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_cmd,
   input  logic [7:0]         req_ch,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [1:0]         rsp_status,
   input  logic [15:0]        rsp_day,
   input  logic [3:0]         rsp_month,
   input  logic signed [16:0] rsp_year_since_1900,
   input  logic [15:0]        rsp_hour,
   input  logic [15:0]        rsp_minute,
   input  logic [15:0]        rsp_second,
   output int                 mismatch_count,
   output int                 pending_count
);

   localparam int WDAY_BASE  = 0;
   localparam int WDAY_NAMES = 14;
   localparam int MON_BASE   = 14;
   localparam int MON_NAMES  = 23;
   localparam int ZONE_BASE  = 37;
   localparam int ZONE_NAMES = 18;
   localparam int DIGIT_CAP  = 65535;
   localparam int YEAR_BIAS  = 1900;

   typedef enum int {NAME_OPEN, NAME_DONE, NAME_BAD} name_verdict_type;

   typedef struct packed {
      hdbp_pkg::status_type status;
      logic [15:0]          day;
      logic [3:0]           month;
      logic signed [16:0]   year;
      logic [15:0]          hour;
      logic [15:0]          minute;
      logic [15:0]          second;
   } date_fields_type;

   string name_table [55] = '{
      "Fri", "Friday", "Mon", "Monday", "Sat", "Saturday", "Sun", "Sunday",
      "Thu", "Thursday", "Tue", "Tuesday", "Wed", "Wednesday",
      "Apr", "April", "Aug", "August", "Dec", "December", "Feb", "February",
      "Jan", "January", "Jul", "July", "Jun", "June", "Mar", "March", "May",
      "Nov", "November", "Oct", "October", "Sep", "September",
      "ADT", "AST", "BDT", "BST", "CDT", "CST", "EDT", "EST", "GMT",
      "HDT", "HST", "MDT", "MST", "NST", "PDT", "PST", "YDT", "YST"
   };
   int month_of [23] = '{4, 4, 8, 8, 12, 12, 2, 2, 1, 1, 7, 7, 6, 6, 3, 3, 5,
                         11, 11, 10, 10, 9, 9};

   hdbp_pkg::phase_type phase;
   logic [22:0]         live_names;
   int                  name_len;
   int                  day_acc;
   int                  month_num;
   int                  year_acc;
   int                  hour_acc;
   int                  minute_acc;
   int                  second_acc;
   int                  failures = 0;
   date_fields_type     awaited_dates [$];

   function automatic bit is_digit(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic bit is_letter(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic int add_digit(int acc, logic [7:0] c);
      int v;
      v = acc * 10 + (c - 8'h30);
      return (v > DIGIT_CAP) ? DIGIT_CAP : v;
   endfunction

   function automatic void open_name();
      live_names = '1;
      name_len   = 0;
   endfunction

   function automatic void clear_date();
      phase = hdbp_pkg::PH_START;
      open_name();
      day_acc    = 0;
      month_num  = 0;
      year_acc   = 0;
      hour_acc   = 0;
      minute_acc = 0;
      second_acc = 0;
   endfunction

   function automatic name_verdict_type name_step(int base, int count, bit delim,
                                                  logic [7:0] c, output int value);
      logic [22:0] hits;
      string       word;
      hits  = '0;
      value = 0;
      if (delim) begin
         for (int i = 0; i < count; i++) begin
            if (live_names[i] && name_table[base + i].len() == name_len) begin
               if (base == MON_BASE) value = month_of[i];
               return NAME_DONE;
            end
         end
         return NAME_BAD;
      end
      if (name_len >= NAME_LIMIT) return NAME_BAD;
      for (int i = 0; i < count; i++) begin
         word = name_table[base + i];
         if (live_names[i] && name_len < word.len() && word[name_len] == c) hits[i] = 1'b1;
      end
      if (hits == '0) return NAME_BAD;
      live_names = hits;
      name_len++;
      return NAME_OPEN;
   endfunction

   function automatic hdbp_pkg::status_type date_byte(logic [7:0] c);
      name_verdict_type verdict;
      int               value;
      if (phase == hdbp_pkg::PH_START) begin
         if (is_digit(c)) begin
            day_acc = c - 8'h30;
            phase   = hdbp_pkg::PH_DAY;
            return hdbp_pkg::ST_CONTINUE;
         end
         open_name();
         phase = hdbp_pkg::PH_WEEKDAY;
      end else if (phase == hdbp_pkg::PH_PRE_MONTH) begin
         if (c == hdbp_pkg::CH_SPACE) return hdbp_pkg::ST_CONTINUE;
         if (!is_letter(c)) return hdbp_pkg::ST_ERROR;
         open_name();
         phase = hdbp_pkg::PH_MONTH;
      end else if (phase == hdbp_pkg::PH_PRE_ZONE) begin
         if (c == hdbp_pkg::CH_SPACE) return hdbp_pkg::ST_CONTINUE;
         if (!is_letter(c)) return hdbp_pkg::ST_ERROR;
         open_name();
         phase = hdbp_pkg::PH_ZONE;
      end
      case (phase)
         hdbp_pkg::PH_WEEKDAY: begin
            verdict = name_step(WDAY_BASE, WDAY_NAMES,
                                c == hdbp_pkg::CH_SPACE || c == hdbp_pkg::CH_COMMA, c, value);
            if (verdict == NAME_OPEN) return hdbp_pkg::ST_CONTINUE;
            if (verdict == NAME_BAD || c != hdbp_pkg::CH_COMMA) return hdbp_pkg::ST_ERROR;
            phase = hdbp_pkg::PH_PRE_DAY;
            return hdbp_pkg::ST_CONTINUE;
         end
         hdbp_pkg::PH_PRE_DAY: begin
            if (c == hdbp_pkg::CH_SPACE) return hdbp_pkg::ST_CONTINUE;
            if (!is_digit(c)) return hdbp_pkg::ST_ERROR;
            day_acc = c - 8'h30;
            phase   = hdbp_pkg::PH_DAY;
            return hdbp_pkg::ST_CONTINUE;
         end
         hdbp_pkg::PH_DAY: begin
            if (is_digit(c)) begin
               day_acc = add_digit(day_acc, c);
               return hdbp_pkg::ST_CONTINUE;
            end
            if (c == hdbp_pkg::CH_SPACE || c == hdbp_pkg::CH_DASH) begin
               phase = hdbp_pkg::PH_PRE_MONTH;
               return hdbp_pkg::ST_CONTINUE;
            end
            return hdbp_pkg::ST_ERROR;
         end
         hdbp_pkg::PH_MONTH: begin
            verdict = name_step(MON_BASE, MON_NAMES,
                                c == hdbp_pkg::CH_SPACE || c == hdbp_pkg::CH_DASH, c, value);
            if (verdict == NAME_OPEN) return hdbp_pkg::ST_CONTINUE;
            if (verdict == NAME_BAD) return hdbp_pkg::ST_ERROR;
            month_num = value;
            phase     = hdbp_pkg::PH_PRE_YEAR;
            return hdbp_pkg::ST_CONTINUE;
         end
         hdbp_pkg::PH_PRE_YEAR: begin
            if (c == hdbp_pkg::CH_SPACE) return hdbp_pkg::ST_CONTINUE;
            if (!is_digit(c)) return hdbp_pkg::ST_ERROR;
            year_acc = c - 8'h30;
            phase    = hdbp_pkg::PH_YEAR;
            return hdbp_pkg::ST_CONTINUE;
         end
         hdbp_pkg::PH_YEAR: begin
            if (is_digit(c)) begin
               year_acc = add_digit(year_acc, c);
               return hdbp_pkg::ST_CONTINUE;
            end
            if (c == hdbp_pkg::CH_SPACE) begin
               year_acc = year_acc - YEAR_BIAS;
               phase    = hdbp_pkg::PH_PRE_HOUR;
               return hdbp_pkg::ST_CONTINUE;
            end
            return hdbp_pkg::ST_ERROR;
         end
         hdbp_pkg::PH_PRE_HOUR: begin
            if (c == hdbp_pkg::CH_SPACE) return hdbp_pkg::ST_CONTINUE;
            if (!is_digit(c)) return hdbp_pkg::ST_ERROR;
            hour_acc = c - 8'h30;
            phase    = hdbp_pkg::PH_HOUR;
            return hdbp_pkg::ST_CONTINUE;
         end
         hdbp_pkg::PH_HOUR: begin
            if (is_digit(c)) begin
               hour_acc = add_digit(hour_acc, c);
               return hdbp_pkg::ST_CONTINUE;
            end
            if (c == hdbp_pkg::CH_COLON) begin
               minute_acc = 0;
               phase      = hdbp_pkg::PH_MINUTE;
               return hdbp_pkg::ST_CONTINUE;
            end
            return hdbp_pkg::ST_ERROR;
         end
         hdbp_pkg::PH_MINUTE: begin
            if (is_digit(c)) begin
               minute_acc = add_digit(minute_acc, c);
               return hdbp_pkg::ST_CONTINUE;
            end
            if (c == hdbp_pkg::CH_COLON) begin
               second_acc = 0;
               phase      = hdbp_pkg::PH_SECOND;
               return hdbp_pkg::ST_CONTINUE;
            end
            return hdbp_pkg::ST_ERROR;
         end
         hdbp_pkg::PH_SECOND: begin
            if (is_digit(c)) begin
               second_acc = add_digit(second_acc, c);
               return hdbp_pkg::ST_CONTINUE;
            end
            if (c == hdbp_pkg::CH_SPACE) begin
               phase = hdbp_pkg::PH_PRE_ZONE;
               return hdbp_pkg::ST_CONTINUE;
            end
            return hdbp_pkg::ST_ERROR;
         end
         hdbp_pkg::PH_ZONE: begin
            verdict = name_step(ZONE_BASE, ZONE_NAMES,
                                c == hdbp_pkg::CH_SPACE || c == hdbp_pkg::CH_CR ||
                                c == hdbp_pkg::CH_LF, c, value);
            if (verdict == NAME_OPEN) return hdbp_pkg::ST_CONTINUE;
            if (verdict == NAME_BAD) return hdbp_pkg::ST_ERROR;
            phase = hdbp_pkg::PH_DONE;
            return hdbp_pkg::ST_COMPLETE;
         end
         default: begin
            return hdbp_pkg::ST_ERROR;
         end
      endcase
   endfunction

   function automatic date_fields_type predict_date(logic [1:0] cmd, logic [7:0] c);
      date_fields_type r;
      int              value;
      r.status = hdbp_pkg::ST_CONTINUE;
      case (cmd)
         hdbp_pkg::CMD_BYTE: begin
            if (phase == hdbp_pkg::PH_DONE) begin
               r.status = hdbp_pkg::ST_ERROR;
            end else begin
               r.status = date_byte(c);
               if (r.status == hdbp_pkg::ST_ERROR) phase = hdbp_pkg::PH_ERR;
            end
         end
         hdbp_pkg::CMD_END: begin
            if (phase == hdbp_pkg::PH_ZONE &&
                name_step(ZONE_BASE, ZONE_NAMES, 1'b1, hdbp_pkg::CH_SPACE, value) == NAME_DONE)
            begin
               r.status = hdbp_pkg::ST_COMPLETE;
               phase    = hdbp_pkg::PH_DONE;
            end else begin
               r.status = hdbp_pkg::ST_ERROR;
               if (phase != hdbp_pkg::PH_DONE) phase = hdbp_pkg::PH_ERR;
            end
         end
         hdbp_pkg::CMD_RESTART: begin
            clear_date();
         end
         default: begin
         end
      endcase
      r.day    = 16'(day_acc);
      r.month  = 4'(month_num);
      r.year   = 17'(year_acc);
      r.hour   = 16'(hour_acc);
      r.minute = 16'(minute_acc);
      r.second = 16'(second_acc);
      return r;
   endfunction

   always @(posedge clock) begin
      date_fields_type seen;
      date_fields_type want;
      if (reset) begin
         clear_date();
         awaited_dates.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_status, rsp_day, rsp_month, rsp_year_since_1900,
                    rsp_hour, rsp_minute, rsp_second};
            if (awaited_dates.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("Result transfer with nothing expected: status %0d day %0d",
                           seen.status, seen.day);
            end else begin
               want = awaited_dates.pop_front();
               if (seen !== want) begin
                  failures++;
                  if (failures <= 10) begin
                     $write("Mismatch at %0t: expected status %0d day %0d month %0d",
                            $realtime, want.status, want.day, want.month);
                     $display(" year %0d %0d:%0d:%0d", $signed(want.year),
                              want.hour, want.minute, want.second);
                     $write("                 got status %0d day %0d month %0d",
                            seen.status, seen.day, seen.month);
                     $display(" year %0d %0d:%0d:%0d", $signed(seen.year),
                              seen.hour, seen.minute, seen.second);
                  end
               end
            end
         end
         if (req_valid && req_ready) awaited_dates.push_back(predict_date(req_cmd, req_ch));
      end
      pending_count  <= awaited_dates.size();
      mismatch_count <= failures;
   end

endmodule

FILE: bench/tb_http_date_byte_parser_core.sv
`timescale 1ns / 1ps
module tb_http_date_byte_parser_core;

   localparam int         ITEM_TARGET  = 1150;
   localparam int         CYCLE_LIMIT  = 500000;
   localparam int         HOLD_CYCLES  = 150;
   localparam int         DRAIN_CYCLES = 20;
   localparam logic [1:0] CMD_UNUSED   = 2'd3;

   typedef enum int {PACE_STEADY, PACE_LIGHT, PACE_HEAVY} pace_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_cmd;
   logic [7:0]         req_ch;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [1:0]         rsp_status;
   logic [15:0]        rsp_day;
   logic [3:0]         rsp_month;
   logic signed [16:0] rsp_year_since_1900;
   logic [15:0]        rsp_hour;
   logic [15:0]        rsp_minute;
   logic [15:0]        rsp_second;
   int                 mismatch_count;
   int                 pending_count;
   int                 items_sent = 0;
   int                 cycle_count = 0;
   bit                 hold_results = 1'b0;
   pace_type           sender_pace = PACE_LIGHT;
   logic [7:0]         date_text [$];

   string weekdays [14] = '{"Fri", "Friday", "Mon", "Monday", "Sat", "Saturday", "Sun",
                            "Sunday", "Thu", "Thursday", "Tue", "Tuesday", "Wed",
                            "Wednesday"};
   string months [23] = '{"Apr", "April", "Aug", "August", "Dec", "December", "Feb",
                          "February", "Jan", "January", "Jul", "July", "Jun", "June",
                          "Mar", "March", "May", "Nov", "November", "Oct", "October",
                          "Sep", "September"};
   string zones [18] = '{"ADT", "AST", "BDT", "BST", "CDT", "CST", "EDT", "EST", "GMT",
                         "HDT", "HST", "MDT", "MST", "NST", "PDT", "PST", "YDT", "YST"};
   string awkward = " ,-:\r\n09aZ+";

   http_date_byte_parser_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cmd             (req_cmd),
      .req_ch              (req_ch),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_day             (rsp_day),
      .rsp_month           (rsp_month),
      .rsp_year_since_1900 (rsp_year_since_1900),
      .rsp_hour            (rsp_hour),
      .rsp_minute          (rsp_minute),
      .rsp_second          (rsp_second)
   );

   http_date_checker scoreboard (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_cmd             (req_cmd),
      .req_ch              (req_ch),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_day             (rsp_day),
      .rsp_month           (rsp_month),
      .rsp_year_since_1900 (rsp_year_since_1900),
      .rsp_hour            (rsp_hour),
      .rsp_minute          (rsp_minute),
      .rsp_second          (rsp_second),
      .mismatch_count      (mismatch_count),
      .pending_count       (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int run;
      int pick;
      rsp_ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_results) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_results = 1'b0;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
               rsp_ready <= 1'b1;
               run = $urandom_range(1, 30);
            end else if (pick < 92) begin
               rsp_ready <= 1'b0;
               run = $urandom_range(1, 3);
            end else begin
               rsp_ready <= 1'b0;
               run = $urandom_range(8, 40);
            end
            repeat (run) @(posedge clock);
         end
      end
   end

   function automatic int sender_gap();
      int pick;
      pick = $urandom_range(0, 99);
      case (sender_pace)
         PACE_STEADY: begin
            return 0;
         end
         PACE_LIGHT: begin
            if (pick < 80) return 0;
            if (pick < 97) return $urandom_range(1, 3);
            return $urandom_range(10, 40);
         end
         default: begin
            if (pick < 40) return 0;
            if (pick < 92) return $urandom_range(1, 4);
            return $urandom_range(5, 25);
         end
      endcase
   endfunction

   // The payload of the previous transfer stays put during a gap; valid alone drops.
   task automatic send_item(logic [1:0] cmd, logic [7:0] ch);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_ch    <= ch;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic send_text(string s);
      foreach (s[i]) send_item(hdbp_pkg::CMD_BYTE, s[i]);
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   function automatic void add_text(string s);
      foreach (s[i]) date_text.push_back(s[i]);
   endfunction

   function automatic void add_digits(int count);
      repeat (count) date_text.push_back(8'h30 + 8'($urandom_range(0, 9)));
   endfunction

   function automatic void add_spaces(int most);
      repeat ($urandom_range(0, most)) date_text.push_back(hdbp_pkg::CH_SPACE);
   endfunction

   function automatic int digit_count(int least, int usual);
      if ($urandom_range(0, 9) == 0) return $urandom_range(least, 7);
      return $urandom_range(least, usual);
   endfunction

   function automatic void build_date();
      date_text.delete();
      if ($urandom_range(0, 1)) begin
         add_text(weekdays[$urandom_range(0, 13)]);
         date_text.push_back(hdbp_pkg::CH_COMMA);
         add_spaces(2);
      end
      add_digits(digit_count(1, 2));
      date_text.push_back($urandom_range(0, 1) ? hdbp_pkg::CH_SPACE : hdbp_pkg::CH_DASH);
      add_spaces(1);
      add_text(months[$urandom_range(0, 22)]);
      date_text.push_back($urandom_range(0, 1) ? hdbp_pkg::CH_SPACE : hdbp_pkg::CH_DASH);
      add_spaces(1);
      add_digits($urandom_range(0, 1) ? 4 : digit_count(1, 2));
      date_text.push_back(hdbp_pkg::CH_SPACE);
      add_spaces(1);
      add_digits(digit_count(1, 2));
      date_text.push_back(hdbp_pkg::CH_COLON);
      add_digits(digit_count(0, 2));
      date_text.push_back(hdbp_pkg::CH_COLON);
      add_digits(digit_count(0, 2));
      date_text.push_back(hdbp_pkg::CH_SPACE);
      add_spaces(1);
      add_text(zones[$urandom_range(0, 17)]);
   endfunction

   task automatic send_ending();
      case ($urandom_range(0, 3))
         0: send_item(hdbp_pkg::CMD_BYTE, hdbp_pkg::CH_SPACE);
         1: send_item(hdbp_pkg::CMD_BYTE, hdbp_pkg::CH_CR);
         2: send_item(hdbp_pkg::CMD_BYTE, hdbp_pkg::CH_LF);
         default: send_item(hdbp_pkg::CMD_END, 8'($urandom_range(0, 255)));
      endcase
      repeat ($urandom_range(0, 2))
         send_item($urandom_range(0, 1) ? hdbp_pkg::CMD_BYTE : hdbp_pkg::CMD_END,
                   8'($urandom_range(0, 255)));
   endtask

   task automatic send_good_date();
      send_item(hdbp_pkg::CMD_RESTART, 8'($urandom_range(0, 255)));
      build_date();
      foreach (date_text[i]) send_item(hdbp_pkg::CMD_BYTE, date_text[i]);
      send_ending();
   endtask

   task automatic send_broken_date();
      int cut;
      int where;
      send_item(hdbp_pkg::CMD_RESTART, 8'($urandom_range(0, 255)));
      build_date();
      case ($urandom_range(0, 3))
         0: begin
            where = $urandom_range(0, date_text.size() - 1);
            if ($urandom_range(0, 1))
               date_text[where] = 8'($urandom_range(0, 255));
            else
               date_text[where] = awkward[$urandom_range(0, awkward.len() - 1)];
            foreach (date_text[i]) send_item(hdbp_pkg::CMD_BYTE, date_text[i]);
            send_ending();
         end
         1: begin
            cut = $urandom_range(0, date_text.size() - 1);
            for (int i = 0; i < cut; i++) send_item(hdbp_pkg::CMD_BYTE, date_text[i]);
            send_item(hdbp_pkg::CMD_END, 8'($urandom_range(0, 255)));
         end
         2: begin
            where = $urandom_range(0, date_text.size());
            date_text.insert(where, 8'h61 + 8'($urandom_range(0, 25)));
            foreach (date_text[i]) send_item(hdbp_pkg::CMD_BYTE, date_text[i]);
            send_ending();
         end
         default: begin
            if ($urandom_range(0, 1))
               send_text("Wednesday");
            else
               send_text("7-September");
            send_item(hdbp_pkg::CMD_BYTE, 8'h61 + 8'($urandom_range(0, 25)));
         end
      endcase
   endtask

   initial begin
      bit held;
      bit drained;
      int kind;
      held      = 1'b0;
      drained   = 1'b0;
      req_valid = 1'b0;
      req_cmd   = hdbp_pkg::CMD_BYTE;
      req_ch    = 8'h00;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_item(CMD_UNUSED, 8'hFF);
      send_item(hdbp_pkg::CMD_END, 8'h00);
      send_item(hdbp_pkg::CMD_BYTE, "x");
      send_item(hdbp_pkg::CMD_RESTART, 8'hA5);
      send_text("Mon ");
      send_item(hdbp_pkg::CMD_RESTART, 8'h5A);
      send_item(hdbp_pkg::CMD_BYTE, 8'h00);
      send_item(hdbp_pkg::CMD_RESTART, 8'h00);
      send_text("1-May-0 0:0:0 +");

      while (items_sent < ITEM_TARGET) begin
         sender_pace = pace_type'($urandom_range(0, 2));
         if (!held && items_sent > 300) begin
            held         = 1'b1;
            hold_results = 1'b1;
            sender_pace  = PACE_STEADY;
         end
         if ((!drained && items_sent > 600) || $urandom_range(0, 39) == 0) begin
            drained = 1'b1;
            wait_until_drained();
         end
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            send_good_date();
         end else if (kind < 90) begin
            send_broken_date();
         end else begin
            repeat ($urandom_range(4, 16))
               send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
         end
      end

      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: files.f
design/hdbp_pkg.sv
design/http_date_byte_parser_core.sv
bench/http_date_checker.sv
bench/tb_http_date_byte_parser_core.sv
